### design/quadratic_probe_hash_table_macros.svh
// Assertion macros for the quadratic probe hash table checker.
// Depends on nothing; included by the checker file.
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define QPHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define QPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/qpht_pkg.sv
// Shared constants, codes and controller/datapath interface types.
// Used by every module of the quadratic probe hash table but the generic RAM.
`default_nettype none

package qpht_pkg;

    // Default sizing and fixed field widths.
    localparam int DEF_MAX_SLOTS = 16384;
    localparam int DEF_KEY_BITS  = 20;
    localparam int TSIZE_W       = 15;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 14;
    localparam int COUNT_W       = 15;
    localparam int CMD_W         = 2;

    localparam logic [TSIZE_W-1:0] RESET_TSIZE = 15'd16381;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // Source of the probe count in a result word.
    typedef enum logic [1:0] {
        CNT_ZERO,
        CNT_NEXT,
        CNT_SIZE,
        CNT_SIZE1
    } t_cnt_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                mod_step;
        logic                probe_init;
        logic                rd;
        logic                advance;
        logic                wr_key;
        logic                clr_init;
        logic                clr_wr;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_keep;
        t_cnt_sel            res_cnt;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_done;
        logic slot_valid;
        logic key_match;
        logic last_probe;
        logic clr_done;
    } t_dp_stat;

endpackage

`default_nettype wire

### design/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table: controller, datapath and
// configuration port. Depends on qpht_pkg, qpht_ctrl and qpht_dp.
//
//  Channel   Handshake                 Word
//  input     i_valid / o_stall         i_command, i_key
//  output    o_valid / i_stall         o_status, o_slot_index, o_probe_count
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (table size)
//
// For insert and lookup the home slot comes from a one-bit-per-cycle
// remainder unit, then each probe is a read and a check on the single
// slot memory read port.
// Clear sweeps the slot memory, then gives its word.
// After reset the same sweep runs with o_stall high.
// A finished word waits in the output register while the next command runs.
`default_nettype none

module quadratic_probe_hash_table
    import qpht_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int KEY_BITS  = DEF_KEY_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [CMD_W-1:0]    i_command,
    input  wire logic [KEY_BITS-1:0] i_key,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [COUNT_W-1:0]       o_probe_count,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [TSIZE_W-1:0]  i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The size register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    qpht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stall   (i_stall),
        .i_stat    (w_stat),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .o_cmd     (w_cmd)
    );

    qpht_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_key         (i_key),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_probe_count (o_probe_count)
    );

endmodule

`default_nettype wire

### design/qpht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`default_nettype none

module qpht_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/qpht_dp.sv
// Datapath: size register, home-slot remainder unit, probe walker,
// slot memory and result word registers. Depends on qpht_pkg and qpht_ram.
`default_nettype none

module qpht_dp
    import qpht_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int KEY_BITS  = DEF_KEY_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [TSIZE_W-1:0]  i_cfg_data,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_stat                 o_stat,
    output logic [STATUS_W-1:0]      o_status,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [COUNT_W-1:0]       o_probe_count
);

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int SIZE_W = $clog2(MAX_SLOTS + 2);
    localparam int CMP_W  = (SIZE_W > TSIZE_W) ? SIZE_W : TSIZE_W;
    localparam int BIT_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    logic [TSIZE_W-1:0]  r_tsize;
    logic [SIZE_W-1:0]   r_size;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_kshift;
    logic [BIT_W-1:0]    r_bit;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   r_pos;
    logic [SIZE_W-1:0]   r_step;
    logic [SIZE_W-1:0]   r_i;
    logic [IDX_W-1:0]    r_clr;
    logic [STATUS_W-1:0] r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic [COUNT_W-1:0]  r_count;

    logic [CMP_W-1:0]    w_tsize_x;
    logic [SIZE_W-1:0]   w_live;
    logic [SIZE_W:0]     w_trial;
    logic [SIZE_W-1:0]   w_rem_n;
    logic [SIZE_W:0]     w_psum;
    logic [SIZE_W-1:0]   w_pos_n;
    logic [SIZE_W:0]     w_ssum;
    logic [SIZE_W-1:0]   w_step_n;
    logic [SIZE_W-1:0]   w_cnt;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [KEY_BITS:0]   w_wdata;
    logic [KEY_BITS:0]   w_rdata;

    // Clamp the written size into the usable range.
    always_comb begin
        w_tsize_x = CMP_W'(r_tsize);
        if (w_tsize_x < CMP_W'(2)) begin
            w_live = SIZE_W'(2);
        end else if (w_tsize_x > CMP_W'(MAX_SLOTS)) begin
            w_live = SIZE_W'(MAX_SLOTS);
        end else begin
            w_live = SIZE_W'(w_tsize_x);
        end
    end

    // One restoring remainder step per cycle, key bits from the top down.
    always_comb begin
        w_trial = {r_rem, r_kshift[KEY_BITS-1]};
        if (w_trial >= {1'b0, r_size}) begin
            w_rem_n = SIZE_W'(w_trial - {1'b0, r_size});
        end else begin
            w_rem_n = SIZE_W'(w_trial);
        end
    end

    // Next probe: position grows by 2i+1 and that increment by 2, both mod size.
    always_comb begin
        w_psum = {1'b0, r_pos} + {1'b0, r_step};
        if (w_psum >= {1'b0, r_size}) begin
            w_pos_n = SIZE_W'(w_psum - {1'b0, r_size});
        end else begin
            w_pos_n = SIZE_W'(w_psum);
        end
        w_ssum = {1'b0, r_step} + (SIZE_W + 1)'(2);
        if (w_ssum >= {1'b0, r_size}) begin
            w_step_n = SIZE_W'(w_ssum - {1'b0, r_size});
        end else begin
            w_step_n = SIZE_W'(w_ssum);
        end
    end

    // Probe count of the result word.
    always_comb begin
        case (i_cmd.res_cnt)
            CNT_ZERO:  w_cnt = '0;
            CNT_NEXT:  w_cnt = r_i + SIZE_W'(1);
            CNT_SIZE:  w_cnt = r_size;
            CNT_SIZE1: w_cnt = r_size + SIZE_W'(1);
            default:   w_cnt = '0;
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsize <= RESET_TSIZE;
        end else if (i_cfg_we) begin
            r_tsize <= i_cfg_data;
        end
    end

    // Clear sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_init) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + IDX_W'(1);
        end
    end

    // Operand capture, remainder unit and probe walker.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size   <= w_live;
            r_key    <= i_key;
            r_kshift <= i_key;
            r_bit    <= BIT_W'(KEY_BITS - 1);
            r_rem    <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem    <= w_rem_n;
            r_kshift <= r_kshift << 1;
            r_bit    <= r_bit - BIT_W'(1);
        end
        if (i_cmd.probe_init) begin
            r_pos  <= r_rem;
            r_step <= SIZE_W'(1);
            r_i    <= '0;
        end else if (i_cmd.advance) begin
            r_pos  <= w_pos_n;
            r_step <= w_step_n;
            r_i    <= r_i + SIZE_W'(1);
        end
    end

    // Result word registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_slot   <= i_cmd.res_keep ? SLOT_W'(r_pos) : '0;
            r_count  <= COUNT_W'(w_cnt);
        end
    end

    // Slot memory: valid bit on top of the stored key.
    assign w_we    = i_cmd.clr_wr | i_cmd.wr_key;
    assign w_waddr = i_cmd.clr_wr ? r_clr : r_pos[IDX_W-1:0];
    assign w_wdata = i_cmd.clr_wr ? '0 : {1'b1, r_key};

    qpht_ram #(
        .WIDTH (KEY_BITS + 1),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_pos[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // Status back to the controller.
    assign o_stat.mod_done   = (r_bit == '0);
    assign o_stat.slot_valid = w_rdata[KEY_BITS];
    assign o_stat.key_match  = (w_rdata[KEY_BITS-1:0] == r_key);
    assign o_stat.last_probe = (r_i == r_size - SIZE_W'(1));
    assign o_stat.clr_done   = (r_clr == IDX_W'(MAX_SLOTS - 1));

    assign o_status      = r_status;
    assign o_slot_index  = r_slot;
    assign o_probe_count = r_count;

endmodule

`default_nettype wire

### design/qpht_ctrl.sv
// Controller state machine: input handshake, operation sequencing and
// output valid. Depends on qpht_pkg.
`default_nettype none

module qpht_ctrl
    import qpht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic             i_stall,
    input  wire t_dp_stat         i_stat,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_dp_cmd               o_cmd
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_IDLE,
        S_MOD,
        S_HOME,
        S_RD,
        S_CHK,
        S_SWEEP,
        S_CLRRES
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CMD_W-1:0] r_op;
    logic [CMD_W-1:0] n_op;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_accept;
    logic             w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        case (r_state)
            S_BOOT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_op = i_command;
                    if (i_command == CMD_CLEAR) begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_SWEEP;
                    end else if (i_command == CMD_INSERT || i_command == CMD_LOOKUP) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                // Insert ends on an empty slot; lookup on empty or match; both end after the last probe.
                if (!i_stat.slot_valid) begin
                    if (w_out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_cnt  = CNT_NEXT;
                        if (r_op == CMD_INSERT) begin
                            o_cmd.wr_key     = 1'b1;
                            o_cmd.res_status = ST_INSERTED;
                            o_cmd.res_keep   = 1'b1;
                        end else begin
                            o_cmd.res_status = ST_NOT_FOUND;
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_op == CMD_LOOKUP && i_stat.key_match) begin
                    if (w_out_free) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_FOUND;
                        o_cmd.res_keep   = 1'b1;
                        o_cmd.res_cnt    = CNT_NEXT;
                        n_state          = S_IDLE;
                    end
                end else if (i_stat.last_probe) begin
                    if (w_out_free) begin
                        o_cmd.res_load = 1'b1;
                        if (r_op == CMD_INSERT) begin
                            o_cmd.res_status = ST_FULL;
                            o_cmd.res_cnt    = CNT_SIZE;
                        end else begin
                            o_cmd.res_status = ST_NOT_FOUND;
                            o_cmd.res_cnt    = CNT_SIZE1;
                        end
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SWEEP: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_CLRRES;
                end
            end
            S_CLRRES: begin
                if (w_out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_CLEARED;
                    o_cmd.res_cnt    = CNT_ZERO;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set by a new result word, dropped when it is taken.
    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (o_cmd.res_load) begin
            n_out_valid = 1'b1;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BOOT;
            r_op        <= CMD_INSERT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

### design/qpht_checker.sv
// Port-level checker for the quadratic probe hash table, with its bind.
// Depends on qpht_pkg and the assertion macro header.
`default_nettype none

`include "quadratic_probe_hash_table_macros.svh"

module qpht_checker
    import qpht_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [SLOT_W-1:0]   o_slot_index,
    input wire logic [COUNT_W-1:0]  o_probe_count
);

    logic [STATUS_W+SLOT_W+COUNT_W-1:0] w_word;
    logic                               w_hold;
    logic                               w_code_ok;
    logic                               w_clear;
    logic                               w_miss;
    logic                               w_zero_word;

    // Decoded views of the output word.
    assign w_word      = {o_status, o_slot_index, o_probe_count};
    assign w_hold      = o_valid && i_stall;
    assign w_code_ok   = o_status inside {ST_INSERTED, ST_FULL, ST_FOUND, ST_NOT_FOUND, ST_CLEARED};
    assign w_clear     = (o_status == ST_CLEARED);
    assign w_miss      = (o_status == ST_FULL) || (o_status == ST_NOT_FOUND);
    assign w_zero_word = (o_slot_index == '0) && (o_probe_count == '0);

    // A stalled word stays on the port unchanged.
    `QPHT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, w_hold, o_valid && $stable(w_word), "word changed")

    // Only defined status codes appear.
    `QPHT_ASSERT_NOW(a_code, i_clk, i_rst_n, o_valid, w_code_ok, "bad status")

    // A clear reports no slot and no probes.
    `QPHT_ASSERT_NOW(a_clear, i_clk, i_rst_n, o_valid && w_clear, w_zero_word, "clear not zero")

    // Failed operations report slot zero.
    `QPHT_ASSERT_NOW(a_miss, i_clk, i_rst_n, o_valid && w_miss, o_slot_index == '0, "miss with slot")

    // Insert and lookup examine at least one slot.
    `QPHT_ASSERT_NOW(a_count, i_clk, i_rst_n, o_valid && !w_clear, o_probe_count != '0, "no probes")

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_slot_index  (o_slot_index),
    .o_probe_count (o_probe_count)
);

`default_nettype wire

### tb/tb.sv
// Testbench for quadratic_probe_hash_table: directed and random commands
// checked word by word against a predictor kept inside the testbench.
// Depends on qpht_pkg and the quadratic_probe_hash_table design.
`timescale 1ns / 100ps

module tb;
    import qpht_pkg::*;

    localparam int SLOTS     = DEF_MAX_SLOTS;
    localparam int KEYW      = DEF_KEY_BITS;
    localparam int LIMIT     = 10000000;
    localparam int LONG_HOLD = 2000;
    localparam int SETTLE    = 200;

    // Command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEYW-1:0]  key;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  cnt;
    } res_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command = CMD_INSERT;
    logic [KEYW-1:0]     i_key = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [COUNT_W-1:0]  o_probe_count;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [TSIZE_W-1:0]  i_cfg_data = '0;

    quadratic_probe_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_probe_count (o_probe_count),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Predicted table contents and configuration.
    bit              slot_used [0:SLOTS-1];
    logic [KEYW-1:0] slot_key [0:SLOTS-1];
    logic [TSIZE_W-1:0] cfg_size = RESET_TSIZE;

    op_t  cmd_queue [$];
    res_t result_queue [$];
    op_t  key_pool [$];

    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int offered = 0;
    int accepted = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    longint cycles = 0;

    // Clock with a 4 ns period.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL quadratic_probe_hash_table");
            $finish;
        end
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Works out the result word of one command and updates the predicted table.
    function automatic void hash_predict(input op_t op);
        int     s;
        longint pos;
        bit     done;
        res_t   r;
        s    = (cfg_size < 2) ? 2 : (cfg_size > SLOTS) ? SLOTS : int'(cfg_size);
        done = 1'b0;
        r    = '0;
        if (op.cmd == CMD_CLEAR) begin
            foreach (slot_used[j]) slot_used[j] = 1'b0;
            r.st = ST_CLEARED;
            result_queue.push_back(r);
        end else if (op.cmd == CMD_INSERT) begin
            for (int i = 0; i < s && !done; i++) begin
                pos = (longint'(op.key) + longint'(i) * i) % s;
                if (!slot_used[pos]) begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = op.key;
                    r.st   = ST_INSERTED;
                    r.slot = SLOT_W'(pos);
                    r.cnt  = COUNT_W'(i + 1);
                    done   = 1'b1;
                end
            end
            if (!done) begin
                r.st  = ST_FULL;
                r.cnt = COUNT_W'(s);
            end
            result_queue.push_back(r);
        end else if (op.cmd == CMD_LOOKUP) begin
            for (int i = 0; i < s && !done; i++) begin
                pos = (longint'(op.key) + longint'(i) * i) % s;
                if (!slot_used[pos]) begin
                    r.st  = ST_NOT_FOUND;
                    r.cnt = COUNT_W'(i + 1);
                    done  = 1'b1;
                end else if (slot_key[pos] == op.key) begin
                    r.st   = ST_FOUND;
                    r.slot = SLOT_W'(pos);
                    r.cnt  = COUNT_W'(i + 1);
                    done   = 1'b1;
                end
            end
            if (!done) begin
                r.st  = ST_NOT_FOUND;
                r.cnt = COUNT_W'(s + 1);
            end
            result_queue.push_back(r);
        end
    endfunction

    // Accepted input words feed the predictor; accepted output words are checked.
    always @(posedge i_clk) begin
        res_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_queue.size() == 0) begin
                report("unexpected word, status", o_status, -1);
            end else begin
                want = result_queue.pop_front();
                if (o_status !== want.st) report("status", o_status, want.st);
                if (o_slot_index !== want.slot) report("slot_index", o_slot_index, want.slot);
                if (o_probe_count !== want.cnt) report("probe_count", o_probe_count, want.cnt);
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            hash_predict(op_t'{cmd: i_command, key: i_key});
            accepted <= accepted + 1;
        end
    end

    // Sender: offers the next pending command once the last one was taken.
    always @(negedge i_clk) begin
        op_t op;
        if (i_rst_n && (!i_valid || accepted == offered)) begin
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                op = cmd_queue.pop_front();
                i_valid   <= 1'b1;
                i_command <= op.cmd;
                i_key     <= op.key;
                offered   <= offered + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Waits until every command was taken and every word has come back.
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_valid || result_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(input int value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= TSIZE_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_size = TSIZE_W'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_op(input logic [CMD_W-1:0] c, input int unsigned k);
        cmd_queue.push_back(op_t'{cmd: c, key: KEYW'(k)});
    endtask

    // One random phase: mostly inserts and lookups over a small key pool so
    // that collisions, hits and full probe sequences are common.
    task automatic random_phase(input int size, input int count, input int mode);
        int unsigned r;
        int unsigned k;
        int sends [4] = '{0, 52, 0, 34};
        int recvs [4] = '{0, 0, 52, 34};
        wait_drained();
        write_size(size);
        send_idle = sends[mode];
        recv_idle = recvs[mode];
        key_pool.delete();
        for (int j = 0; j < 8; j++)
            key_pool.push_back(op_t'{cmd: CMD_INSERT, key: KEYW'($urandom)});
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 199);
            k = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)].key : $urandom;
            if (r < 3)        push_op(CMD_CLEAR, $urandom);
            else if (r < 6)   push_op(CMD_UNKNOWN, k);
            else if (r < 100) push_op(CMD_INSERT, k);
            else              push_op(CMD_LOOKUP, k);
        end
    endtask

    initial begin
        int sizes [18] = '{2, 3, 5, 0, 1, 11, 13, 31, 4, 9, 61, 127, 32767, 16384, 2, 7, 13, 251};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset size: key extremes, miss, unknown command, clear.
        push_op(CMD_INSERT, 0);
        push_op(CMD_INSERT, 20'hFFFFF);
        push_op(CMD_LOOKUP, 20'hFFFFF);
        push_op(CMD_LOOKUP, 0);
        push_op(CMD_LOOKUP, 12345);
        push_op(CMD_UNKNOWN, 7);
        push_op(CMD_CLEAR, 20'hFFFFF);
        push_op(CMD_LOOKUP, 0);

        // Directed words on seven slots: one home slot reaches only four of them,
        // so the fifth insert is full and a miss walks every probe.
        wait_drained();
        write_size(7);
        for (int j = 0; j < 5; j++) push_op(CMD_INSERT, 7 * j);
        push_op(CMD_LOOKUP, 700);
        push_op(CMD_LOOKUP, 14);
        push_op(CMD_LOOKUP, 1);
        push_op(CMD_INSERT, 14);
        push_op(CMD_LOOKUP, 14);
        push_op(CMD_INSERT, 20'hFFFFF);
        push_op(CMD_LOOKUP, 20'hFFFFF);
        push_op(CMD_CLEAR, 0);
        push_op(CMD_LOOKUP, 14);

        // Random phases over several sizes and idling patterns.
        foreach (sizes[p]) begin
            random_phase(sizes[p], (sizes[p] > 300) ? 20 : 105, p % 4);
            // Hold the output back while the sender keeps offering words.
            if (p == 6) hold_req = hold_req + 1;
        end

        wait_drained();
        if (errors == 0) begin
            $display("PASS quadratic_probe_hash_table");
        end else begin
            $display("FAIL quadratic_probe_hash_table");
        end
        $finish;
    end

endmodule
